@@ hw/rtl/gpm_pkg.sv @@
// Shared types, codes, constants and helper functions of the gamepad report merger.
`timescale 1ns / 1ps
`default_nettype none

package gpm_pkg;

  localparam logic [3:0]  HAT_CENTRE   = 4'd8;
  localparam logic [7:0]  STICK_CENTRE = 8'd128;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  // Register reset values
  localparam logic        RST_REMOTE_ENABLED = 1'b0;
  localparam logic [15:0] RST_BUTTON_A_MASK  = 16'd4;
  localparam logic [15:0] RST_BUTTON_LR_MASK = 16'd48;
  localparam logic [15:0] RST_TAP_TICKS      = 16'd100;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd500;
  localparam logic [15:0] RST_RESEND_TICKS   = 16'd50;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned IN_PAYLD_W  = 58;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned RPT_W       = 52;

  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KEY_UP    = 3'd0,
    KEY_DOWN  = 3'd1,
    KEY_LEFT  = 3'd2,
    KEY_RIGHT = 3'd3,
    KEY_OK    = 3'd4,
    KEY_BACK  = 3'd5
  } key_e;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_SHORT   = 2'd2,
    ACT_LONG    = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    CFG_REMOTE_ENABLED = 3'd0,
    CFG_BUTTON_A_MASK  = 3'd1,
    CFG_BUTTON_LR_MASK = 3'd2,
    CFG_TAP_TICKS      = 3'd3,
    CFG_TIMEOUT_TICKS  = 3'd4,
    CFG_RESEND_TICKS   = 3'd5
  } cfg_idx_e;

  // Remote state and report share one layout, buttons in the lowest bits
  typedef struct packed {
    logic [7:0]  ry;
    logic [7:0]  rx;
    logic [7:0]  ly;
    logic [7:0]  lx;
    logic [3:0]  hat;
    logic [15:0] buttons;
  } rpt_t;

  localparam rpt_t RPT_NEUTRAL = '{ry: STICK_CENTRE, rx: STICK_CENTRE, ly: STICK_CENTRE,
                                   lx: STICK_CENTRE, hat: HAT_CENTRE, buttons: 16'd0};

  // Input item, key in the lowest bits, kind on top
  typedef struct packed {
    logic [1:0]  mode;
    logic        link_up;
    logic [7:0]  remote_ry;
    logic [7:0]  remote_rx;
    logic [7:0]  remote_ly;
    logic [7:0]  remote_lx;
    logic [3:0]  remote_hat;
    logic [15:0] remote_buttons;
    logic [1:0]  key_action;
    logic [2:0]  key;
  } item_t;

  typedef struct packed {
    logic        remote_enabled;
    logic [15:0] button_a_mask;
    logic [15:0] button_lr_mask;
    logic [15:0] tap_ticks;
    logic [15:0] timeout_ticks;
    logic [15:0] resend_ticks;
  } cfg_t;

  // Reports of one item: count, report for all later beats, first report
  typedef struct packed {
    logic [1:0] n;
    rpt_t       rep1;
    rpt_t       rep0;
  } bndl_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  // Eight-way hat from held direction bits; opposite keys cancel
  function automatic logic [3:0] resolve_hat(input logic [3:0] d);
    logic up, down, left, right;
    up    = d[0] & ~d[1];
    down  = d[1] & ~d[0];
    left  = d[2] & ~d[3];
    right = d[3] & ~d[2];
    if (up)        resolve_hat = right ? 4'd1 : (left ? 4'd7 : 4'd0);
    else if (down) resolve_hat = right ? 4'd3 : (left ? 4'd5 : 4'd4);
    else           resolve_hat = right ? 4'd2 : (left ? 4'd6 : HAT_CENTRE);
  endfunction

  function automatic rpt_t make_rpt(input logic [3:0] hat, input logic [15:0] btn,
                                    input rpt_t rem);
    rpt_t r;
    logic [3:0] rhat;
    r         = rem;
    rhat      = (rem.hat > HAT_CENTRE) ? HAT_CENTRE : rem.hat;
    r.buttons = rem.buttons | btn;
    r.hat     = (hat != HAT_CENTRE) ? hat : rhat;
    make_rpt  = r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gpm_core.sv @@
// Merger state and the single-pass computation of the reports of one item.
`timescale 1ns / 1ps
`default_nettype none

module gpm_core import gpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output bndl_t      bndl_o
);

  logic [3:0]  dir_q, dir_d;
  logic [15:0] btn_q, btn_d;
  logic        pend_q, pend_d;
  logic [15:0] te_q, te_d;
  rpt_t        rem_q, rem_d;
  logic [15:0] su_q, su_d;
  logic [15:0] sr_q, sr_d;
  logic        c1, c2, c3;
  logic [1:0]  n;
  logic [3:0]  dbit;
  rpt_t        rep0, rep1;

  always_comb begin
    dir_d  = dir_q;
    btn_d  = btn_q;
    pend_d = pend_q;
    te_d   = te_q;
    rem_d  = rem_q;
    su_d   = su_q;
    sr_d   = sr_q;
    c1     = 1'b0;
    c2     = 1'b0;
    c3     = 1'b0;
    n      = 2'd0;
    dbit   = 4'd1 << item_i.key[1:0];
    unique case (mode_e'(item_i.mode))
      MODE_KEY: begin
        if (item_i.key <= KEY_RIGHT && item_i.key_action <= ACT_RELEASE) begin
          // set or clear one direction bit
          if (item_i.key_action == ACT_PRESS) dir_d = dir_q | dbit;
          else                                dir_d = dir_q & ~dbit;
          n = 2'd1;
        end else if (item_i.key == KEY_OK) begin
          unique case (act_e'(item_i.key_action))
            ACT_SHORT: begin
              btn_d  = btn_q | cfg_i.button_a_mask;
              pend_d = 1'b1;
              te_d   = '0;
              n      = 2'd1;
            end
            ACT_LONG: begin
              btn_d = btn_q | cfg_i.button_lr_mask;
              n     = 2'd1;
            end
            ACT_RELEASE: begin
              btn_d = btn_q & ~cfg_i.button_lr_mask;
              n     = 2'd1;
            end
            ACT_PRESS: ;
          endcase
        end
      end
      MODE_REMOTE: begin
        if (cfg_i.remote_enabled) begin
          rem_d = '{ry: item_i.remote_ry, rx: item_i.remote_rx, ly: item_i.remote_ly,
                    lx: item_i.remote_lx, hat: item_i.remote_hat,
                    buttons: item_i.remote_buttons};
          su_d  = '0;
          n     = 2'd1;
        end
      end
      MODE_TICK: begin
        // advance counters, then neutral, tap end and resend in that order
        su_d = sat_inc(su_q);
        sr_d = sat_inc(sr_q);
        if (pend_q) te_d = sat_inc(te_q);
        c1 = cfg_i.remote_enabled && (!item_i.link_up || su_d > cfg_i.timeout_ticks) &&
             (rem_q != RPT_NEUTRAL);
        c2 = pend_q && (te_d >= cfg_i.tap_ticks);
        c3 = sr_d >= cfg_i.resend_ticks;
        if (c1) rem_d = RPT_NEUTRAL;
        if (c2) begin
          pend_d = 1'b0;
          btn_d  = btn_q & ~cfg_i.button_a_mask;
        end
        if (c3) sr_d = '0;
        n = {1'b0, c1} + {1'b0, c2} + {1'b0, c3};
      end
      MODE_NONE: ;
    endcase
    // later beats all see the final state; a neutral beat still sees the tap bits
    rep1 = make_rpt(resolve_hat(dir_d), btn_d, rem_d);
    rep0 = c1 ? make_rpt(resolve_hat(dir_d), btn_q, rem_d) : rep1;
  end

  assign bndl_o = '{n: n, rep1: rep1, rep0: rep0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= '0;
      btn_q  <= '0;
      pend_q <= 1'b0;
      te_q   <= '0;
      rem_q  <= RPT_NEUTRAL;
      su_q   <= '0;
      sr_q   <= '0;
    end else if (fire_i) begin
      dir_q  <= dir_d;
      btn_q  <= btn_d;
      pend_q <= pend_d;
      te_q   <= te_d;
      rem_q  <= rem_d;
      su_q   <= su_d;
      sr_q   <= sr_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpm_outq.sv @@
// Two-entry queue of report bundles, sent out one report beat per cycle while ready_i is high.
`timescale 1ns / 1ps
`default_nettype none

module gpm_outq import gpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire bndl_t bndl_i,
  output logic       full_o,
  output rpt_t       rpt_o,
  output logic       last_o,
  output logic       valid_o,
  input  wire logic  ready_i
);

  bndl_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic [1:0]  sub_q;
  bndl_t       head;
  logic        beat, pop;

  assign head    = mem_q[rd_ptr_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign rpt_o   = (sub_q == 2'd0) ? head.rep0 : head.rep1;
  assign last_o  = sub_q == head.n - 2'd1;
  assign beat    = valid_o && ready_i;
  assign pop     = beat && last_o;

  // store bundle payload
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= bndl_i;
  end

  // pointers, fill count and beat index within the head bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push_i) cnt_q <= cnt_q - 2'd1;
      if (pop)       sub_q <= '0;
      else if (beat) sub_q <= sub_q + 2'd1;
    end
  end

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> head.n != 2'd0) else $error("queued bundle holds no report");

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> sub_q < head.n) else $error("beat index past bundle end");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2) else $error("push into full bundle queue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost count");

endmodule

`default_nettype wire

@@ hw/rtl/gamepad_report_merger.sv @@
// Top level of the gamepad report merger: ports, input register and configuration.
`timescale 1ns / 1ps
`default_nettype none

// Merges local key events, remote controller updates and ticks into gamepad
// reports. Each input beat is taken into an input register, processed in a
// single pass against the merger state, and yields zero to three report
// beats, which are queued as one bundle and sent one beat per cycle while
// m_axis_tready is high; tlast marks the final report of an input beat. The
// input side accepts one beat per cycle as long as the two-entry bundle queue
// has room, so items giving one report stream at one per cycle while the
// output is ready; an item giving k reports sends them as k consecutive
// beats. Configuration writes take effect at the next edge and must happen
// while no item is in flight.

module gamepad_report_merger import gpm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0]   cfg_wdata_i,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // key[2:0], key_action[4:3], remote_buttons[20:5], remote_hat[24:21],
  // remote_lx[32:25], remote_ly[40:33], remote_rx[48:41], remote_ry[56:49],
  // link_up[57], zero fill[63:58]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // report stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // report_buttons[15:0], report_hat[19:16], report_lx[27:20],
  // report_ly[35:28], report_rx[43:36], report_ry[51:44], zero fill[55:52]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tlast
);

  cfg_t   cfg_q;
  item_t  in_q;
  logic   in_valid_q;
  logic   full, fire;
  bndl_t  bndl;
  rpt_t   rpt;

  // process the held item when the bundle queue has room
  assign fire          = in_valid_q && !full;
  assign s_axis_tready = !in_valid_q || fire;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{remote_enabled: RST_REMOTE_ENABLED, button_a_mask: RST_BUTTON_A_MASK,
                 button_lr_mask: RST_BUTTON_LR_MASK, tap_ticks: RST_TAP_TICKS,
                 timeout_ticks: RST_TIMEOUT_TICKS, resend_ticks: RST_RESEND_TICKS};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REMOTE_ENABLED: cfg_q.remote_enabled <= cfg_wdata_i[0];
        CFG_BUTTON_A_MASK:  cfg_q.button_a_mask  <= cfg_wdata_i;
        CFG_BUTTON_LR_MASK: cfg_q.button_lr_mask <= cfg_wdata_i;
        CFG_TAP_TICKS:      cfg_q.tap_ticks      <= cfg_wdata_i;
        CFG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_wdata_i;
        CFG_RESEND_TICKS:   cfg_q.resend_ticks   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= item_t'({s_axis_tuser, s_axis_tdata[IN_PAYLD_W-1:0]});
    end
  end

  gpm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .bndl_o (bndl)
  );

  gpm_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire && bndl.n != 2'd0),
    .bndl_i  (bndl),
    .full_o  (full),
    .rpt_o   (rpt),
    .last_o  (m_axis_tlast),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - RPT_W){1'b0}}, rpt};

endmodule

`default_nettype wire
